// ===== rtl/pdt_pkg.sv =====
// Shared types and constants of the pinch distance tracker.
`timescale 1ns / 1ps
`default_nettype none
package pdt_pkg;

   localparam int EVT_TYPE_W  = 5;
   localparam int EVT_CODE_W  = 10;
   localparam int EVT_VALUE_W = 32;
   localparam int DIST_W      = 13;
   localparam int COORD_W_MAX = 16;
   localparam int SLOT_W      = 1;
   localparam int COUNT_W     = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   localparam logic [EVT_TYPE_W-1:0] EV_SYN = 5'd0;
   localparam logic [EVT_TYPE_W-1:0] EV_ABS = 5'd3;

   localparam logic [EVT_CODE_W-1:0] CODE_REPORT = 10'h000;
   localparam logic [EVT_CODE_W-1:0] CODE_SLOT   = 10'h02f;
   localparam logic [EVT_CODE_W-1:0] CODE_POS_X  = 10'h035;
   localparam logic [EVT_CODE_W-1:0] CODE_POS_Y  = 10'h036;
   localparam logic [EVT_CODE_W-1:0] CODE_TRACK  = 10'h039;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = 2'd3;
   localparam logic [COUNT_W-1:0] COUNT_EMIT = 2'd1;
   localparam logic [DIST_W-1:0]  DIST_MAX   = 13'h1fff;

   typedef enum logic [2:0] {
      OP_REPORT = 3'd0,
      OP_SLOT   = 3'd1,
      OP_TRACK  = 3'd2,
      OP_POSX   = 3'd3,
      OP_POSY   = 3'd4
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   slot_ok;
      logic [SLOT_W-1:0]      slot_idx;
      logic                   lift;
      logic [COORD_W_MAX-1:0] coord;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/pdt_front.sv =====
// Event decoder: classifies incoming events into commands and drops ignored ones.
`timescale 1ns / 1ps
`default_nettype none
module pdt_front #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [pdt_pkg::EVT_TYPE_W-1:0]       req_event_type,
   input  wire logic [pdt_pkg::EVT_CODE_W-1:0]       req_event_code,
   input  wire logic signed [pdt_pkg::EVT_VALUE_W-1:0] req_event_value,
   input  wire logic                                 q_ready,
   output logic                                      q_push,
   output pdt_pkg::cmd_type                          q_cmd
);

   localparam logic [pdt_pkg::EVT_VALUE_W-1:0] COORD_LIMIT =
      pdt_pkg::EVT_VALUE_W'((64'd1 << COORD_BITS) - 64'd1);

   logic                                known;
   logic [pdt_pkg::EVT_VALUE_W-1:0]     uval;
   logic [pdt_pkg::EVT_VALUE_W-1:0]     clamped;

   assign req_ready = q_ready;
   assign uval      = $unsigned(req_event_value);

   always_comb begin
      if (uval[pdt_pkg::EVT_VALUE_W-1]) begin
         clamped = '0;
      end else if (uval > COORD_LIMIT) begin
         clamped = COORD_LIMIT;
      end else begin
         clamped = uval;
      end
   end

   always_comb begin
      known          = 1'b0;
      q_cmd.op       = pdt_pkg::OP_REPORT;
      // A slot number is good when it is 0 or 1, which leaves the upper bits clear.
      q_cmd.slot_ok  = (uval[pdt_pkg::EVT_VALUE_W-1:pdt_pkg::SLOT_W] == '0);
      q_cmd.slot_idx = uval[pdt_pkg::SLOT_W-1:0];
      q_cmd.lift     = &uval;
      q_cmd.coord    = clamped[pdt_pkg::COORD_W_MAX-1:0];
      if (req_event_type == pdt_pkg::EV_SYN) begin
         if (req_event_code == pdt_pkg::CODE_REPORT) begin
            known    = 1'b1;
            q_cmd.op = pdt_pkg::OP_REPORT;
         end
      end else if (req_event_type == pdt_pkg::EV_ABS) begin
         unique case (req_event_code)
            pdt_pkg::CODE_SLOT: begin
               known    = 1'b1;
               q_cmd.op = pdt_pkg::OP_SLOT;
            end
            pdt_pkg::CODE_TRACK: begin
               known    = 1'b1;
               q_cmd.op = pdt_pkg::OP_TRACK;
            end
            pdt_pkg::CODE_POS_X: begin
               known    = 1'b1;
               q_cmd.op = pdt_pkg::OP_POSX;
            end
            pdt_pkg::CODE_POS_Y: begin
               known    = 1'b1;
               q_cmd.op = pdt_pkg::OP_POSY;
            end
            default: begin
               known = 1'b0;
            end
         endcase
      end
   end

   assign q_push = req_valid && q_ready && known;

endmodule
`default_nettype wire

// ===== rtl/pdt_queue.sv =====
// Short command queue between the decoder and the execution side.
`timescale 1ns / 1ps
`default_nettype none
module pdt_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire pdt_pkg::cmd_type push_cmd,
   output logic                  push_ready,
   input  wire logic             pop,
   output logic                  pop_valid,
   output pdt_pkg::cmd_type      pop_cmd
);

   pdt_pkg::cmd_type              entry_ff [pdt_pkg::QUEUE_DEPTH];
   logic [pdt_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [pdt_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [pdt_pkg::QPTR_W:0]      count_ff, count_in;
   logic                          do_push, do_pop;

   assign push_ready = (count_ff != (pdt_pkg::QPTR_W+1)'(pdt_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == pdt_pkg::QPTR_W'(pdt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == pdt_pkg::QPTR_W'(pdt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/pdt_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pdt_isqrt #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [2*COORD_BITS:0] radicand,
   output logic                       done,
   output logic [COORD_BITS:0]        root
);

   localparam int NP = COORD_BITS + 1;
   localparam int CW = $clog2(NP);

   logic [2*NP-1:0] n_ff, n_in;
   logic [NP-1:0]   rem_ff, rem_in;
   logic [NP-1:0]   root_ff, root_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [NP+1:0]   rem_sh, trial, rem_sub;
   logic            take;

   // Bring down the next bit pair and try to append a one to the root.
   assign rem_sh  = {rem_ff, n_ff[2*NP-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign take    = (rem_sh >= trial);
   assign rem_sub = rem_sh - trial;

   always_comb begin
      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = {1'b0, radicand};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in    = {n_ff[2*NP-3:0], 2'b00};
         rem_in  = take ? rem_sub[NP-1:0] : rem_sh[NP-1:0];
         root_in = {root_ff[NP-2:0], take};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NP - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ===== rtl/pdt_back.sv =====
// Execution side: slot and contact state, distance sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module pdt_back #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid,
   input  wire pdt_pkg::cmd_type            q_cmd,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [pdt_pkg::DIST_W-1:0]       rsp_pinch_distance
);

   localparam int NP = COORD_BITS + 1;
   localparam int SW = 2 * COORD_BITS;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_SUM    = 5'b00100,
      ST_ROOT   = 5'b01000,
      ST_SEND   = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   logic [pdt_pkg::SLOT_W-1:0]     cur_slot_ff, cur_slot_in;
   logic                           slot_valid_ff, slot_valid_in;
   logic                           got_pos_ff, got_pos_in;
   logic [1:0]                     active_ff, active_in;
   logic [pdt_pkg::COUNT_W-1:0]    count_ff [2];
   logic [pdt_pkg::COUNT_W-1:0]    count_in [2];
   logic [COORD_BITS-1:0]          x_ff [2];
   logic [COORD_BITS-1:0]          x_in [2];
   logic [COORD_BITS-1:0]          y_ff [2];
   logic [COORD_BITS-1:0]          y_in [2];
   logic [COORD_BITS-1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic [SW-1:0]                  sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [pdt_pkg::DIST_W-1:0]     res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pdt_pkg::DIST_W-1:0]     rsp_dist_ff, rsp_dist_in;
   logic                           root_start, root_done;
   logic [SW:0]                    radicand;
   logic [NP-1:0]                  root;
   logic                           root_big;

   assign radicand = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign root_big = ((NP + pdt_pkg::DIST_W)'(root) >
                      (NP + pdt_pkg::DIST_W)'(pdt_pkg::DIST_MAX));

   pdt_isqrt #(
      .COORD_BITS (COORD_BITS)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   always_comb begin
      state_in      = state_ff;
      cur_slot_in   = cur_slot_ff;
      slot_valid_in = slot_valid_ff;
      got_pos_in    = got_pos_ff;
      active_in     = active_ff;
      count_in      = count_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sqx_in        = sqx_ff;
      sqy_in        = sqy_ff;
      res_in        = res_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      q_pop         = 1'b0;
      root_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               // Slot changes and reports both close the pending frame of the old slot.
               if (q_cmd.op == pdt_pkg::OP_REPORT || q_cmd.op == pdt_pkg::OP_SLOT) begin
                  if (got_pos_ff && slot_valid_ff &&
                      count_ff[cur_slot_ff] != pdt_pkg::COUNT_MAX) begin
                     count_in[cur_slot_ff] = count_ff[cur_slot_ff] + 1'b1;
                  end
                  got_pos_in = 1'b0;
               end
               case (q_cmd.op)
                  pdt_pkg::OP_REPORT: begin
                     if (active_ff[0] && active_ff[1] &&
                         count_in[0] > pdt_pkg::COUNT_EMIT &&
                         count_in[1] > pdt_pkg::COUNT_EMIT) begin
                        dx_in    = (x_ff[1] > x_ff[0]) ? x_ff[1] - x_ff[0] : x_ff[0] - x_ff[1];
                        dy_in    = (y_ff[1] > y_ff[0]) ? y_ff[1] - y_ff[0] : y_ff[0] - y_ff[1];
                        state_in = ST_SQUARE;
                     end
                  end
                  pdt_pkg::OP_SLOT: begin
                     if (q_cmd.slot_ok) begin
                        cur_slot_in   = q_cmd.slot_idx;
                        slot_valid_in = 1'b1;
                     end else begin
                        slot_valid_in = 1'b0;
                     end
                  end
                  pdt_pkg::OP_TRACK: begin
                     if (slot_valid_ff) begin
                        active_in[cur_slot_ff] = !q_cmd.lift;
                        count_in[cur_slot_ff]  = '0;
                     end
                  end
                  pdt_pkg::OP_POSX: begin
                     if (slot_valid_ff) begin
                        x_in[cur_slot_ff] = q_cmd.coord[COORD_BITS-1:0];
                        got_pos_in        = 1'b1;
                     end
                  end
                  pdt_pkg::OP_POSY: begin
                     if (slot_valid_ff) begin
                        y_in[cur_slot_ff] = q_cmd.coord[COORD_BITS-1:0];
                        got_pos_in        = 1'b1;
                     end
                  end
                  default: begin
                     got_pos_in = got_pos_in;
                  end
               endcase
            end
         end
         ST_SQUARE: begin
            sqx_in   = {{COORD_BITS{1'b0}}, dx_ff} * {{COORD_BITS{1'b0}}, dx_ff};
            sqy_in   = {{COORD_BITS{1'b0}}, dy_ff} * {{COORD_BITS{1'b0}}, dy_ff};
            state_in = ST_SUM;
         end
         ST_SUM: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               res_in   = root_big ? pdt_pkg::DIST_MAX : pdt_pkg::DIST_W'(root);
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_slot_ff   <= '0;
         slot_valid_ff <= 1'b1;
         got_pos_ff    <= 1'b0;
         active_ff     <= '0;
         count_ff      <= '{default: '0};
         x_ff          <= '{default: '0};
         y_ff          <= '{default: '0};
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_slot_ff   <= cur_slot_in;
         slot_valid_ff <= slot_valid_in;
         got_pos_ff    <= got_pos_in;
         active_ff     <= active_in;
         count_ff      <= count_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      res_ff      <= res_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pinch_distance = rsp_dist_ff;

endmodule
`default_nettype wire

// ===== rtl/two_finger_pinch_distance_tracker_core.sv =====
// Top level of the two-finger pinch distance tracker.
// Events are taken at one per cycle into a two-entry command queue while it has room; an event that
// updates state is registered in the queue and then retired by the executor from its idle state.
// A report that yields a distance passes the square, sum, root and send states in that order
// (the square root unit runs COORD_BITS + 1 iterations in the root state), and it holds
// the executor, and with it the queue, until the result register takes the distance.
// Synchronous reset empties the queue, clears contacts, counts and positions, selects slot 0.
`timescale 1ns / 1ps
`default_nettype none
module two_finger_pinch_distance_tracker_core #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [pdt_pkg::EVT_TYPE_W-1:0]         req_event_type,
   input  wire logic [pdt_pkg::EVT_CODE_W-1:0]         req_event_code,
   input  wire logic signed [pdt_pkg::EVT_VALUE_W-1:0] req_event_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [pdt_pkg::DIST_W-1:0]                  rsp_pinch_distance
);

   logic             push, push_ready, pop, pop_valid;
   pdt_pkg::cmd_type push_cmd, pop_cmd;

   pdt_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_event_type  (req_event_type),
      .req_event_code  (req_event_code),
      .req_event_value (req_event_value),
      .q_ready         (push_ready),
      .q_push          (push),
      .q_cmd           (push_cmd)
   );

   pdt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   pdt_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (pop_valid),
      .q_cmd              (pop_cmd),
      .q_pop              (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pinch_distance (rsp_pinch_distance)
   );

endmodule
`default_nettype wire

// ===== rtl/pdt_checker.sv =====
// Port-level assertions for the pinch distance tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pdt_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [pdt_pkg::DIST_W-1:0]       rsp_pinch_distance
);

   // The result register holds a stalled transaction.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pinch_distance))
      else $error("result changed while stalled");

   // Reset leaves no result pending and an empty queue ready for events.
   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

endmodule

bind two_finger_pinch_distance_tracker_core pdt_checker u_pdt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_pinch_distance (rsp_pinch_distance)
);
`default_nettype wire
